/* src/vmm_pkg.sv */
// Shared types and constants of the video mode matcher.
// No dependencies; imported by vmm_divider and video_mode_matcher_core.
`default_nettype none
package vmm_pkg;

	localparam int unsigned QTY_COUNT   = 5;
	localparam int unsigned INDEX_LIMIT = 32;
	localparam logic [11:0] LINES_MAX   = 12'hFFF;
	localparam logic [16:0] CLOCK_MAX   = 17'h1FFFF;

	localparam logic [2:0] QTY_APIX  = 3'd0;
	localparam logic [2:0] QTY_ALIN  = 3'd1;
	localparam logic [2:0] QTY_LTOT  = 3'd2;
	localparam logic [2:0] QTY_LINES = 3'd3;
	localparam logic [2:0] QTY_CLOCK = 3'd4;

	localparam logic [1:0] ST_MATCHED     = 2'd0;
	localparam logic [1:0] ST_INVALID     = 2'd1;
	localparam logic [1:0] ST_DISCONNECTED = 2'd2;

	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	localparam logic [1:0] REG_REFCLK = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_ACCEPT = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINES,
		S_MUL,
		S_CLOCK,
		S_RD,
		S_CMP,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
		logic [23:0] divisor;
		logic [5:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [39:0] quotient;
	} div_rsp_t;

	function automatic logic [3:0] miss_cost(input logic [2:0] qty);
		case (qty)
			QTY_APIX:  miss_cost = 4'd1;
			QTY_ALIN:  miss_cost = 4'd1;
			QTY_LTOT:  miss_cost = 4'd2;
			QTY_LINES: miss_cost = 4'd2;
			QTY_CLOCK: miss_cost = 4'd5;
			default:   miss_cost = 4'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

/* src/video_mode_matcher_core.sv */
// Video mode matcher: serial divider for frame lines and pixel clock, then a
// walk over the bound table held in one memory, a read state and a compare state per quantity.
// Load transaction: written to the table on acceptance. Classify: frame lines division,
// product, pixel clock division, read and compare per quantity of each entry, then output; one item
// at a time, input ready again once the result is registered.
// Reset: registers to 26 / 0 / 5, no result pending; table is undefined until written.
`default_nettype none
module video_mode_matcher_core #(
	parameter int unsigned MAX_MODES = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// entry_index, quantity_select, bound_low, bound_high, active_pixels,
	// active_lines, line_total, frame_pixels, refclk_ticks, source_connected
	input  wire logic [127:0] s_tdata,
	// action
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// mode_index, frame_lines, pixel_clock, miss_weight
	output logic      [39:0]  m_tdata,
	// status
	output logic      [1:0]   m_tuser
);
	import vmm_pkg::*;

	localparam int unsigned DEPTH = MAX_MODES * QTY_COUNT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SLIM  = (MAX_MODES < INDEX_LIMIT) ? MAX_MODES : INDEX_LIMIT;

	logic [7:0] refclk_q;
	logic [5:0] count_q;
	logic [3:0] accept_q;

	logic        wr_en;
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refclk_q <= 8'd26;
			count_q  <= 6'd0;
			accept_q <= 4'd5;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_REFCLK: refclk_q <= pwdata[7:0];
				REG_COUNT:  count_q  <= pwdata[5:0];
				REG_ACCEPT: accept_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_REFCLK: prdata = {24'd0, refclk_q};
			REG_COUNT:  prdata = {26'd0, count_q};
			REG_ACCEPT: prdata = {28'd0, accept_q};
			default:    prdata = '0;
		endcase
	end

	// input fields
	logic [4:0]  in_entry;
	logic [2:0]  in_qsel;
	logic [16:0] in_lo, in_hi;
	assign in_entry = s_tdata[4:0];
	assign in_qsel  = s_tdata[7:5];
	assign in_lo    = s_tdata[24:8];
	assign in_hi    = s_tdata[41:25];

	seq_state_t state_q, state_d;
	logic       s_fire;
	assign s_fire = s_tvalid && s_tready;

	logic [11:0] apix_q, alin_q, ltot_q, lines_q;
	logic [23:0] fpix_q, ticks_q;
	logic        conn_q, clock_ok_q;
	logic [16:0] clock_q;
	logic [5:0]  ent_q;
	logic [2:0]  qty_q;
	logic [3:0]  weight_q;
	logic [5:0]  limit;
	logic        found_q;
	logic [4:0]  found_idx_q;
	logic [3:0]  found_w_q;

	assign limit = (count_q > 6'(SLIM)) ? 6'(SLIM) : count_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	vmm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// bound table, {high, low} per slot
	logic [33:0]   mem [DEPTH];
	logic [33:0]   rd_q;
	logic [8:0]    wr_slot9, rd_slot9;
	logic          mem_we;
	logic          mem_rd;

	assign wr_slot9 = {2'b00, in_entry, 2'b00} + {4'd0, in_entry} + {6'd0, in_qsel};
	assign rd_slot9 = {2'b00, ent_q[4:0], 2'b00} + {4'd0, ent_q[4:0]} + {6'd0, qty_q};
	assign mem_we   = s_fire && (s_tuser == ACT_LOAD) && (in_qsel < 3'(QTY_COUNT))
		&& (32'(in_entry) < MAX_MODES);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[AW'(wr_slot9)] <= {in_hi, in_lo};
		if (mem_rd)
			rd_q <= mem[AW'(rd_slot9)];
	end

	// compare of the current quantity
	logic [16:0] meas;
	logic        miss;
	logic [3:0]  weight_n;
	always_comb begin
		case (qty_q)
			QTY_APIX:  meas = {5'd0, apix_q};
			QTY_ALIN:  meas = {5'd0, alin_q};
			QTY_LTOT:  meas = {5'd0, ltot_q};
			QTY_LINES: meas = {5'd0, lines_q};
			default:   meas = clock_q;
		endcase
		miss = (meas < rd_q[16:0]) || (meas > rd_q[33:17]);
		if (qty_q == QTY_CLOCK && !clock_ok_q)
			miss = 1'b1;
		weight_n = miss ? weight_q + miss_cost(qty_q) : weight_q;
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (s_fire && s_tuser == ACT_CLASSIFY)
					state_d = !s_tdata[126] ? S_DONE
						: (s_tdata[77:66] != 12'd0) ? S_LINES : S_MUL;
			S_LINES: if (div_rsp.done) state_d = S_MUL;
			S_MUL:   state_d = (ltot_q != 12'd0 && lines_q != 12'd0 && ticks_q != 24'd0)
				? S_CLOCK : ((limit != 6'd0) ? S_RD : S_DONE);
			S_CLOCK: if (div_rsp.done) state_d = (limit != 6'd0) ? S_RD : S_DONE;
			S_RD:    state_d = S_CMP;
			S_CMP:
				if (qty_q == QTY_CLOCK) begin
					if (weight_n <= accept_q || ent_q + 6'd1 >= limit)
						state_d = S_DONE;
					else
						state_d = S_RD;
				end else begin
					state_d = S_RD;
				end
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = (state_q == S_IDLE);
		mem_rd           = (state_q == S_RD);
		div_req.start    = 1'b0;
		div_req.dividend = {fpix_q, 16'd0};
		div_req.divisor  = {12'd0, ltot_q};
		div_req.steps    = 6'd24;
		case (state_q)
			S_IDLE: begin
				div_req.start    = s_fire && s_tuser == ACT_CLASSIFY && s_tdata[126]
					&& s_tdata[77:66] != 12'd0;
				div_req.dividend = {s_tdata[101:78], 16'd0};
				div_req.divisor  = {12'd0, s_tdata[77:66]};
			end
			S_MUL: begin
				div_req.start    = (ltot_q != 12'd0 && lines_q != 12'd0 && ticks_q != 24'd0);
				div_req.dividend = {{8'd0, fpix_q} * {24'd0, refclk_q}, 8'd0};
				div_req.divisor  = ticks_q;
				div_req.steps    = 6'd40;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE:
				if (s_fire) begin
					apix_q     <= s_tdata[53:42];
					alin_q     <= s_tdata[65:54];
					ltot_q     <= s_tdata[77:66];
					fpix_q     <= s_tdata[101:78];
					ticks_q    <= s_tdata[125:102];
					conn_q     <= s_tdata[126];
					lines_q    <= '0;
					clock_q    <= '0;
					clock_ok_q <= 1'b0;
					ent_q      <= '0;
					qty_q      <= QTY_APIX;
					weight_q   <= '0;
					found_q    <= 1'b0;
				end
			S_LINES:
				if (div_rsp.done)
					lines_q <= (div_rsp.quotient > {28'd0, LINES_MAX})
						? LINES_MAX : div_rsp.quotient[11:0];
			S_MUL:
				clock_ok_q <= (ltot_q != 12'd0 && lines_q != 12'd0 && ticks_q != 24'd0);
			S_CLOCK:
				if (div_rsp.done)
					clock_q <= (div_rsp.quotient > {23'd0, CLOCK_MAX})
						? CLOCK_MAX : div_rsp.quotient[16:0];
			S_CMP:
				if (qty_q == QTY_CLOCK) begin
					if (weight_n <= accept_q) begin
						found_q     <= 1'b1;
						found_idx_q <= ent_q[4:0];
						found_w_q   <= weight_n;
					end
					ent_q    <= ent_q + 6'd1;
					qty_q    <= QTY_APIX;
					weight_q <= '0;
				end else begin
					qty_q    <= qty_q + 3'd1;
					weight_q <= weight_n;
				end
			S_DONE:
				if (out_free) begin
					if (!conn_q) begin
						m_tuser <= ST_DISCONNECTED;
						m_tdata <= '0;
					end else if (found_q) begin
						m_tuser <= ST_MATCHED;
						m_tdata <= {2'd0, found_w_q, clock_q, lines_q, found_idx_q};
					end else begin
						m_tuser <= ST_INVALID;
						m_tdata <= {2'd0, 4'd0, clock_q, lines_q, 5'd0};
					end
				end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* src/vmm_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on vmm_pkg for the request and response structs.
`default_nettype none
module vmm_divider (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire vmm_pkg::div_req_t req,
	output vmm_pkg::div_rsp_t    rsp
);
	import vmm_pkg::*;

	logic [39:0] dq_q;
	logic [23:0] rem_q;
	logic [23:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] trial;
	logic        fits;

	// dividend must be aligned to the top; quotient shifts in at the bottom
	assign trial = {rem_q, dq_q[39]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[38:0], fits};
			rem_q <= fits ? 24'(trial - {1'b0, div_q}) : trial[23:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule
`default_nettype wire

/* tb/tb_video_mode_matcher_core.sv */
// Self-checking testbench for video_mode_matcher_core: stream stimulus, APB set-up,
// an in-bench timing classifier that predicts results (directed rows carry their own), and a scoreboard.
// Depends on vmm_pkg and the core only.
`timescale 1ns / 1ps
`default_nettype none
module tb_video_mode_matcher_core;
	import vmm_pkg::*;

	localparam int NUM_MODES = 32;
	localparam int DRAIN_CYCLES = 450;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  mode_index;
		logic [11:0] frame_lines;
		logic [16:0] pixel_clock;
		logic [3:0]  miss_weight;
	} verdict_t;

	typedef struct {
		logic        act;
		logic [4:0]  entry;
		logic [2:0]  qty;
		logic [16:0] lo;
		logic [16:0] hi;
		logic [11:0] apix;
		logic [11:0] alin;
		logic [11:0] ltot;
		logic [23:0] fpix;
		logic [23:0] ticks;
		logic        conn;
		bit          typed;
		verdict_t    want;
	} timing_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;

	video_mode_matcher_core #(.MAX_MODES(NUM_MODES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	// shadow of the block's state
	logic [16:0] low_tab [NUM_MODES*5];
	logic [16:0] high_tab [NUM_MODES*5];
	logic [7:0] refclk_mhz = 8'd26;
	logic [5:0] mode_count = 6'd0;
	logic [3:0] accept_weight = 4'd5;

	verdict_t pending_results [$];
	int errors = 0;
	int results_seen = 0;
	int matches_seen = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	function automatic verdict_t classify_timing(timing_item_t it);
		verdict_t v;
		logic [63:0] wide;
		logic [16:0] meas [5];
		bit clk_ok;
		int lim;
		int w;
		bit miss;
		v = '{status: ST_DISCONNECTED, default: '0};
		if (!it.conn)
			return v;
		v.status = ST_INVALID;
		if (it.ltot != 0) begin
			wide = it.fpix / it.ltot;
			v.frame_lines = (wide > 4095) ? LINES_MAX : wide[11:0];
		end
		clk_ok = it.ltot != 0 && v.frame_lines != 0 && it.ticks != 0;
		if (clk_ok) begin
			wide = (64'(it.fpix) * refclk_mhz * 256) / it.ticks;
			v.pixel_clock = (wide > 131071) ? CLOCK_MAX : wide[16:0];
		end
		meas[0] = 17'(it.apix);
		meas[1] = 17'(it.alin);
		meas[2] = 17'(it.ltot);
		meas[3] = 17'(v.frame_lines);
		meas[4] = v.pixel_clock;
		lim = (mode_count > NUM_MODES) ? NUM_MODES : int'(mode_count);
		for (int e = 0; e < lim; e++) begin
			w = 0;
			for (int q = 0; q < 5; q++) begin
				miss = meas[q] < low_tab[e*5+q] || meas[q] > high_tab[e*5+q];
				if (q == 4 && !clk_ok)
					miss = 1'b1;
				if (miss)
					w += (q < 2) ? 1 : (q < 4) ? 2 : 5;
			end
			if (w <= accept_weight) begin
				v.status = ST_MATCHED;
				v.mode_index = e[4:0];
				v.miss_weight = w[3:0];
				return v;
			end
		end
		return v;
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REFCLK: refclk_mhz = val[7:0];
			REG_COUNT:  mode_count = val[5:0];
			REG_ACCEPT: accept_weight = val[3:0];
			default: ;
		endcase
	endtask

	// called at a rising edge; returns at the edge that accepted the transaction, or after a random idle gap
	task automatic send_item(input timing_item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.act;
		s_tdata <= {1'b0, it.conn, it.ticks, it.fpix, it.ltot, it.alin, it.apix,
			it.hi, it.lo, it.qty, it.entry};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// transaction accepted at this edge
		if (it.act == ACT_LOAD) begin
			if (it.qty < QTY_COUNT) begin
				low_tab[it.entry*5+it.qty] = it.lo;
				high_tab[it.entry*5+it.qty] = it.hi;
			end
		end else begin
			pending_results.push_back(it.typed ? it.want : classify_timing(it));
		end
		items_sent++;
		if (!quiet && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic drain(input bit settle);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic timing_item_t rand_measure();
		timing_item_t it;
		int lines;
		int total;
		it = '{act: ACT_CLASSIFY, conn: 1'b1, default: '0};
		it.entry = 5'($urandom);
		it.qty = 3'($urandom);
		it.lo = 17'($urandom);
		it.hi = 17'($urandom);
		it.apix = 12'($urandom);
		it.alin = 12'($urandom);
		case ($urandom_range(9))
			0: begin
				it.ltot = 12'($urandom);
				it.fpix = 24'($urandom);
			end
			1: it.ltot = 12'd0;
			default: begin
				it.ltot = 12'($urandom_range(4095, 1));
				lines = $urandom_range(1200, 1);
				total = int'(it.ltot) * lines + int'($urandom_range(it.ltot - 1));
				it.fpix = (total > 24'hFFFFFF) ? 24'hFFFFFF : 24'(total);
			end
		endcase
		case ($urandom_range(9))
			0: it.ticks = 24'd0;
			1: it.ticks = 24'($urandom);
			default: it.ticks = 24'($urandom_range(24'hFFFFFF, 24'h100000));
		endcase
		if ($urandom_range(19) == 0)
			it.conn = 1'b0;
		return it;
	endfunction

	// Program one entry around a measurement, then classify it or a perturbed copy.
	task automatic fit_and_classify();
		timing_item_t m, ld;
		verdict_t v;
		logic [16:0] val [5];
		int d;
		m = rand_measure();
		m.conn = 1'b1;
		v = classify_timing(m);
		val[0] = 17'(m.apix);
		val[1] = 17'(m.alin);
		val[2] = 17'(m.ltot);
		val[3] = 17'(v.frame_lines);
		val[4] = v.pixel_clock;
		ld = m;
		ld.act = ACT_LOAD;
		ld.entry = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
		for (int q = 0; q < 5; q++) begin
			if ($urandom_range(4) == 0)
				continue;
			d = $urandom_range(1) ? 0 : $urandom_range(60);
			ld.qty = 3'(q);
			ld.lo = (val[q] > d) ? 17'(val[q] - d) : 17'd0;
			ld.hi = (val[q] + d > 131071) ? CLOCK_MAX : 17'(val[q] + d);
			if ($urandom_range(14) == 0) begin
				ld.lo = 17'(ld.hi + 1);
				ld.hi = val[q];
			end
			send_item(ld);
		end
		case ($urandom_range(5))
			0: m.apix = 12'($urandom);
			1: m.alin = 12'($urandom);
			2: m.ticks = 24'($urandom);
			3: m.conn = 1'b0;
			default: ;
		endcase
		send_item(m);
	endtask

	task automatic noise_item();
		timing_item_t it;
		it = rand_measure();
		if ($urandom_range(2) == 0) begin
			it.act = ACT_LOAD;
			// quantities above the pixel clock are ignored by the block
			if ($urandom_range(4) != 0)
				it.qty = 3'($urandom_range(4));
		end
		send_item(it);
	endtask

	// result side: random stalls, one long hold-off on request
	always @(posedge clk) begin : rx_ready
		int hold_left;
		logic rdy;
		rdy = quiet || $urandom_range(99) >= 6;
		if (hold_req && hold_left == 0)
			hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
			if (hold_left == 0)
				hold_req = 1'b0;
		end
		m_tready <= arst_n && rdy;
	end

	always @(posedge clk) begin : scoreboard
		verdict_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[4:0], m_tdata[16:5], m_tdata[33:17], m_tdata[37:34]};
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status == ST_MATCHED)
					matches_seen++;
				if (got.status != want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.mode_index != want.mode_index)
					$display("%0t: mode_index exp %0d got %0d", $time,
						want.mode_index, got.mode_index);
				if (got.frame_lines != want.frame_lines)
					$display("%0t: frame_lines exp %0d got %0d", $time,
						want.frame_lines, got.frame_lines);
				if (got.pixel_clock != want.pixel_clock)
					$display("%0t: pixel_clock exp %0d got %0d", $time,
						want.pixel_clock, got.pixel_clock);
				if (got.miss_weight != want.miss_weight)
					$display("%0t: miss_weight exp %0d got %0d", $time,
						want.miss_weight, got.miss_weight);
				if (got != want)
					errors++;
			end
		end
	end

	initial begin : watchdog
		#20ms;
		$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		timing_item_t directed [$];
		timing_item_t it;
		int phase_items;
		for (int i = 0; i < NUM_MODES*5; i++) begin
			low_tab[i] = '0;
			high_tab[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows; the mode count is still zero, so every classify is unmatched
		it = '{act: ACT_CLASSIFY, conn: 1'b0, typed: 1'b1, default: '0};
		it.apix = '1; it.alin = '1; it.ltot = '1; it.fpix = '1; it.ticks = '1;
		it.want = '{status: ST_DISCONNECTED, default: '0};
		directed.push_back(it);
		it = '{act: ACT_CLASSIFY, conn: 1'b1, typed: 1'b1, default: '0};
		it.fpix = 24'd5000; it.ticks = 24'd1000;
		it.want = '{status: ST_INVALID, default: '0};
		directed.push_back(it);
		it.ltot = 12'd10; it.fpix = 24'd1000; it.ticks = 24'd0;
		it.want = '{status: ST_INVALID, frame_lines: 12'd100, default: '0};
		directed.push_back(it);
		it.ltot = 12'd1; it.fpix = '1; it.ticks = 24'd1;
		it.want = '{status: ST_INVALID, frame_lines: LINES_MAX, pixel_clock: CLOCK_MAX,
			default: '0};
		directed.push_back(it);
		it.ltot = 12'd10; it.fpix = 24'd5; it.ticks = 24'd100;
		it.want = '{status: ST_INVALID, default: '0};
		directed.push_back(it);
		it = '{act: ACT_CLASSIFY, conn: 1'b1, typed: 1'b0, default: '0};
		it.apix = 12'd1920; it.alin = 12'd1080; it.ltot = 12'd2200;
		it.fpix = 24'd2475000; it.ticks = 24'd433333;
		directed.push_back(it);
		for (int q = 0; q < 8; q++) begin
			it = '{act: ACT_LOAD, typed: 1'b0, default: '0};
			it.entry = (q < 5) ? 5'd0 : 5'd31;
			it.qty = 3'(q);
			it.lo = '0;
			it.hi = '1;
			directed.push_back(it);
		end
		foreach (directed[i])
			send_item(directed[i]);
		drain(1'b1);

		// fill the whole table with wide bounds before any entry is searched
		for (int i = 0; i < NUM_MODES*5; i++) begin
			it = '{act: ACT_LOAD, default: '0};
			it.entry = 5'(i / 5);
			it.qty = 3'(i % 5);
			it.lo = 17'($urandom_range(100));
			it.hi = 17'($urandom_range(131071, 60000));
			send_item(it);
		end
		drain(1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin reg_write(REG_REFCLK, 32'd26); reg_write(REG_COUNT, 32'd32);
					reg_write(REG_ACCEPT, 32'd5); end
				1: begin reg_write(REG_REFCLK, 32'd1); reg_write(REG_COUNT, 32'd4);
					reg_write(REG_ACCEPT, 32'd0); end
				2: begin reg_write(REG_REFCLK, 32'd255); reg_write(REG_COUNT, 32'd1);
					reg_write(REG_ACCEPT, 32'd11); end
				3: begin reg_write(REG_COUNT, 32'd0); reg_write(REG_ACCEPT, 32'd3); end
				default: begin
					reg_write(REG_REFCLK, $urandom_range(255, 1));
					reg_write(REG_COUNT, $urandom_range(32));
					reg_write(REG_ACCEPT, $urandom_range(11));
				end
			endcase
			quiet = (ph == 5);
			if (ph == 2)
				hold_req = 1'b1;
			phase_items = items_sent + 32;
			while (items_sent < phase_items) begin
				if ($urandom_range(3) == 0)
					noise_item();
				else
					fit_and_classify();
			end
			// sender waits for every outstanding result before the next setting
			drain(1'b1);
		end
		quiet = 1'b0;
		drain(1'b1);

		$display("Sent %0d items (loads, classifies, ignored loads) over 8 register settings;",
			items_sent);
		$display("checked %0d results, %0d of them matches.", results_seen, matches_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d results missing", errors, pending_results.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
